[rtl/cia_pkg.sv]
// Shared types, operation codes and status codes of the checked integer ALU.
`default_nettype none
package cia_pkg;

  localparam int DATA_WIDTH_DEF = 64;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_MUL = 3'd2;
  localparam logic [2:0] FN_DIV = 3'd3;
  localparam logic [2:0] FN_MOD = 3'd4;
  localparam logic [2:0] FN_POW = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FALLBACK = 2'd1;
  localparam logic [1:0] ST_DIVZERO  = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [63:0] left_operand;
    logic signed [63:0] right_operand;
  } in_t;

  typedef struct packed {
    logic signed [63:0] int_result;
    logic [1:0]         status;
  } out_t;

endpackage
`default_nettype wire

[rtl/checked_int64_alu.sv]
// Top level of the overflow-checked signed integer ALU.
//
//   channel  ports                          beat
//   input    start, busy, in_item           accepted when start & !busy
//   result   out_valid, out_item            high for a single cycle, never stalled
//
// Add, subtract and unused codes: the operands are registered on the accept,
// and the result strobe is registered from the EXEC state. Multiply, divide,
// modulo: the result waits on the bit-serial multiplier or divider; a zero divisor is answered from EXEC.
// Power: one serial multiply for each set exponent bit and one for the square
// while higher exponent bits remain; a negative exponent is answered from EXEC.
// busy is high from the accept until the result strobe; one item at a time.
// Synchronous active-low reset returns to idle with no result pending.
`default_nettype none
module checked_int64_alu #(
  parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire cia_pkg::in_t in_item,
  output logic              out_valid,
  output cia_pkg::out_t     out_item
);
  localparam int W = DATA_WIDTH;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_PCHK = 6'b010000,
    S_PSQ  = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic          pacc_r, pacc_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [W-1:0]  l_r, l_nxt, r_r, r_nxt;
  logic [W-1:0]  acc_r, acc_nxt, fac_r, fac_nxt, exp_r, exp_nxt;
  logic          neg_r, neg_nxt;
  logic          out_valid_r, out_valid_nxt;
  cia_pkg::out_t out_item_r, out_item_nxt;

  logic           mul_go, mul_done, div_go, div_done;
  logic [W-1:0]   mul_a, mul_b, div_a, div_b, quo, rmd;
  logic [2*W-1:0] prod;
  logic [W-1:0]   mval, qv, rv;
  logic           movf;
  logic [W:0]     sum, dif;
  logic           l_min, r_m1;

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    return x[W-1] ? (~x + W'(1)) : x;
  endfunction

  function automatic cia_pkg::out_t make_out(input logic [W-1:0] v, input logic [1:0] st);
    cia_pkg::out_t o;
    o.status     = st;
    o.int_result = (st == cia_pkg::ST_OK) ? 64'($signed(v)) : 64'sd0;
    return o;
  endfunction

  cia_mul #(.DATA_WIDTH(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .go(mul_go), .a_mag(mul_a), .b_mag(mul_b),
    .done(mul_done), .prod(prod)
  );

  cia_div #(.DATA_WIDTH(W)) u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .dvd(div_a), .dvs(div_b),
    .done(div_done), .quo(quo), .rmd(rmd)
  );

  always_comb begin
    // signed range: a negative product may reach exactly the most negative value
    movf = (|prod[2*W-1:W]) | (prod[W-1] & (~neg_r | (|prod[W-2:0])));
    mval = neg_r ? (~prod[W-1:0] + W'(1)) : prod[W-1:0];
    qv   = (l_r[W-1] ^ r_r[W-1]) ? (~quo + W'(1)) : quo;
    rv   = l_r[W-1] ? (~rmd + W'(1)) : rmd;
    sum  = {l_r[W-1], l_r} + {r_r[W-1], r_r};
    dif  = {l_r[W-1], l_r} - {r_r[W-1], r_r};
    l_min = (l_r == {1'b1, {(W-1){1'b0}}});
    r_m1  = &r_r;

    state_nxt     = state_r;
    pacc_nxt      = pacc_r;
    op_nxt        = op_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    acc_nxt       = acc_r;
    fac_nxt       = fac_r;
    exp_nxt       = exp_r;
    neg_nxt       = neg_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mul_go        = 1'b0;
    mul_a         = mag(acc_r);
    mul_b         = mag(fac_r);
    div_go        = 1'b0;
    div_a         = mag(l_r);
    div_b         = mag(r_r);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_item.func;
          l_nxt     = in_item.left_operand[W-1:0];
          r_nxt     = in_item.right_operand[W-1:0];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        case (op_r)
          cia_pkg::FN_ADD:
            out_item_nxt = make_out(sum[W-1:0], (sum[W] ^ sum[W-1]) ?
                                    cia_pkg::ST_FALLBACK : cia_pkg::ST_OK);
          cia_pkg::FN_SUB:
            out_item_nxt = make_out(dif[W-1:0], (dif[W] ^ dif[W-1]) ?
                                    cia_pkg::ST_FALLBACK : cia_pkg::ST_OK);
          cia_pkg::FN_MUL: begin
            mul_go        = 1'b1;
            mul_a         = mag(l_r);
            mul_b         = mag(r_r);
            neg_nxt       = l_r[W-1] ^ r_r[W-1];
            out_valid_nxt = 1'b0;
            state_nxt     = S_MUL;
          end
          cia_pkg::FN_DIV, cia_pkg::FN_MOD: begin
            if (r_r == '0) begin
              out_item_nxt = make_out('0, cia_pkg::ST_DIVZERO);
            end else begin
              div_go        = 1'b1;
              out_valid_nxt = 1'b0;
              state_nxt     = S_DIV;
            end
          end
          cia_pkg::FN_POW: begin
            if (r_r[W-1]) begin
              out_item_nxt = make_out('0, cia_pkg::ST_FALLBACK);
            end else begin
              acc_nxt       = W'(1);
              fac_nxt       = l_r;
              exp_nxt       = r_r;
              out_valid_nxt = 1'b0;
              state_nxt     = S_PCHK;
            end
          end
          default: out_item_nxt = make_out('0, cia_pkg::ST_FALLBACK);
        endcase
      end
      S_MUL: begin
        if (mul_done) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = make_out(mval, movf ? cia_pkg::ST_FALLBACK : cia_pkg::ST_OK);
          state_nxt     = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (op_r == cia_pkg::FN_MOD) begin
            out_item_nxt = make_out(rv, cia_pkg::ST_OK);
          end else if ((l_min && r_m1) || (rmd != '0)) begin
            out_item_nxt = make_out('0, cia_pkg::ST_FALLBACK);
          end else begin
            out_item_nxt = make_out(qv, cia_pkg::ST_OK);
          end
        end
      end
      S_PCHK: begin
        if (exp_r == '0) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = make_out(acc_r, cia_pkg::ST_OK);
          state_nxt     = S_IDLE;
        end else if (exp_r[0]) begin
          mul_go    = 1'b1;
          neg_nxt   = acc_r[W-1] ^ fac_r[W-1];
          pacc_nxt  = 1'b1;
          state_nxt = S_PSQ;
        end else begin
          exp_nxt   = exp_r >> 1;
          mul_go    = 1'b1;
          mul_a     = mag(fac_r);
          neg_nxt   = 1'b0;
          pacc_nxt  = 1'b0;
          state_nxt = S_PSQ;
        end
      end
      S_PSQ: begin
        if (mul_done) begin
          if (movf) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = make_out('0, cia_pkg::ST_FALLBACK);
            state_nxt     = S_IDLE;
          end else if (pacc_r) begin
            // accumulator step done; square only while exponent bits remain
            acc_nxt = mval;
            exp_nxt = exp_r >> 1;
            if (exp_r[W-1:1] == '0) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = make_out(mval, cia_pkg::ST_OK);
              state_nxt     = S_IDLE;
            end else begin
              mul_go   = 1'b1;
              mul_a    = mag(fac_r);
              neg_nxt  = 1'b0;
              pacc_nxt = 1'b0;
            end
          end else begin
            fac_nxt   = mval;
            state_nxt = S_PCHK;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pacc_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pacc_r      <= pacc_nxt;
    end
    op_r       <= op_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    acc_r      <= acc_nxt;
    fac_r      <= fac_nxt;
    exp_r      <= exp_nxt;
    neg_r      <= neg_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
endmodule
`default_nettype wire

[rtl/cia_mul.sv]
// Radix-2 shift-and-add unsigned multiplier, one multiplier bit per cycle.
`default_nettype none
module cia_mul #(
  parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      go,
  input  wire logic [DATA_WIDTH-1:0]     a_mag,
  input  wire logic [DATA_WIDTH-1:0]     b_mag,
  output logic                           done,
  output logic [2*DATA_WIDTH-1:0]        prod
);
  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] hi_r, hi_nxt, lo_r, lo_nxt, mc_r, mc_nxt;
  logic [DATA_WIDTH:0]   sum;

  always_comb begin
    sum      = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mc_r} : '0);
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    mc_nxt   = mc_r;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(DATA_WIDTH);
      hi_nxt  = '0;
      lo_nxt  = b_mag;
      mc_nxt  = a_mag;
    end else if (run_r) begin
      hi_nxt  = sum[DATA_WIDTH:1];
      lo_nxt  = {sum[0], lo_r[DATA_WIDTH-1:1]};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    mc_r  <= mc_nxt;
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};
endmodule
`default_nettype wire

[rtl/cia_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module cia_div #(
  parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  go,
  input  wire logic [DATA_WIDTH-1:0] dvd,
  input  wire logic [DATA_WIDTH-1:0] dvs,
  output logic                       done,
  output logic [DATA_WIDTH-1:0]      quo,
  output logic [DATA_WIDTH-1:0]      rmd
);
  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] q_r, q_nxt, rm_r, rm_nxt, dv_r, dv_nxt;
  logic [DATA_WIDTH:0]   trial, diff;

  always_comb begin
    trial    = {rm_r, q_r[DATA_WIDTH-1]};
    diff     = trial - {1'b0, dv_r};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rm_nxt   = rm_r;
    dv_nxt   = dv_r;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(DATA_WIDTH);
      q_nxt   = dvd;
      rm_nxt  = '0;
      dv_nxt  = dvs;
    end else if (run_r) begin
      // keep the trial difference when it did not go negative
      rm_nxt  = diff[DATA_WIDTH] ? trial[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
      q_nxt   = {q_r[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rm_r  <= rm_nxt;
    dv_r  <= dv_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rmd  = rm_r;
endmodule
`default_nettype wire

[rtl/cia_chk.sv]
// Port-level checker for the checked integer ALU, bound to the top level.
`default_nettype none
module cia_chk (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          out_valid,
  input wire cia_pkg::out_t out_item
);
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result beats back to back");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted beat left block idle");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == cia_pkg::ST_OK ||
                   out_item.status == cia_pkg::ST_FALLBACK ||
                   out_item.status == cia_pkg::ST_DIVZERO))
    else $error("undefined status code");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != cia_pkg::ST_OK) |-> (out_item.int_result == 64'sd0))
    else $error("non-zero value with error status");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy)) else $error("not idle after reset");
endmodule

bind checked_int64_alu cia_chk u_cia_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
`default_nettype wire

[verif/checked_int64_alu_tb.sv]
// Testbench for the checked integer ALU: directed and random beats, scoreboard prediction.
`timescale 1ns / 100ps
module checked_int64_alu_tb;

  localparam logic [2:0] FN_SPARE_LO = 3'd6;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;
  localparam longint I64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
  localparam int N_RANDOM = 1100;
  localparam int CYCLE_LIMIT = 50_000_000;

  class alu_scoreboard;
    cia_pkg::out_t pending[$];
    int            mismatches;

    // exact signed product, flags whether it fits in 64 bits
    function automatic bit mul_fits(longint a, longint b, output longint prod);
      logic signed [127:0] wa, wb, wp;
      wa = a;
      wb = b;
      wp = wa * wb;
      prod = wp[63:0];
      return wp == {{64{wp[63]}}, wp[63:0]};
    endfunction

    function automatic cia_pkg::out_t predict_alu(cia_pkg::in_t it);
      cia_pkg::out_t o;
      longint l, r, v, acc, fac, rem;
      logic signed [64:0] s;
      bit     ok;
      l = it.left_operand;
      r = it.right_operand;
      v = 0;
      o.status = cia_pkg::ST_OK;
      case (it.func)
        cia_pkg::FN_ADD, cia_pkg::FN_SUB: begin
          if (it.func == cia_pkg::FN_ADD) s = {l[63], l} + {r[63], r};
          else s = {l[63], l} - {r[63], r};
          if (s[64] != s[63]) o.status = cia_pkg::ST_FALLBACK;
          else v = s[63:0];
        end
        cia_pkg::FN_MUL: begin
          if (!mul_fits(l, r, v)) o.status = cia_pkg::ST_FALLBACK;
        end
        cia_pkg::FN_DIV: begin
          if (r == 0) o.status = cia_pkg::ST_DIVZERO;
          else if (l == I64_MIN && r == -1) o.status = cia_pkg::ST_FALLBACK;
          else if (l % r != 0) o.status = cia_pkg::ST_FALLBACK;
          else v = l / r;
        end
        cia_pkg::FN_MOD: begin
          if (r == 0) o.status = cia_pkg::ST_DIVZERO;
          else if (r == -1) v = 0;
          else v = l % r;
        end
        cia_pkg::FN_POW: begin
          ok = (r >= 0);
          acc = 1;
          fac = l;
          rem = r;
          while (ok && rem > 0) begin
            if (rem[0]) ok = mul_fits(acc, fac, acc);
            rem = rem >>> 1;
            if (ok && rem > 0) ok = mul_fits(fac, fac, fac);
          end
          if (ok) v = acc;
          else o.status = cia_pkg::ST_FALLBACK;
        end
        default: o.status = cia_pkg::ST_FALLBACK;
      endcase
      o.int_result = (o.status == cia_pkg::ST_OK) ? v : 64'sd0;
      return o;
    endfunction

    function void note_input(cia_pkg::in_t it);
      pending.push_back(predict_alu(it));
    endfunction

    function void check_result(cia_pkg::out_t got);
      cia_pkg::out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: int_result=%0d status=%0d",
                   got.int_result, got.status);
        return;
      end
      want = pending.pop_front();
      if (got.int_result !== want.int_result || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: int_result exp %0d got %0d, status exp %0d got %0d",
                   want.int_result, got.int_result, want.status, got.status);
      end
    endfunction
  endclass

  logic          clk, rst_n, start, busy, out_valid;
  cia_pkg::in_t  in_item;
  cia_pkg::out_t out_item;
  int            cycles;
  alu_scoreboard sb;

  checked_int64_alu dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    sb = new();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && start && !busy) sb.note_input(in_item);
    if (rst_n && out_valid) sb.check_result(out_item);
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // holds start until the beat is taken; the caller decides whether start stays up
  task automatic send_beat(logic [2:0] fn, longint l, longint r);
    start <= 1'b1;
    in_item <= '{func: fn, left_operand: l, right_operand: r};
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic longint pick_operand();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return longint'($urandom_range(0, 200)) - 100;
      2: case ($urandom_range(0, 4))
           0: return I64_MIN;
           1: return I64_MAX;
           2: return 0;
           3: return -1;
           default: return 1;
         endcase
      3: return ($urandom_range(0, 1) ? 64'sd1 : -64'sd1) <<< $urandom_range(0, 63);
      4: return longint'(int'($urandom));
      default: return {$urandom, $urandom} >>> $urandom_range(1, 62);
    endcase
  endfunction

  task automatic send_random();
    logic [2:0] fn;
    longint l, r;
    fn = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    l = pick_operand();
    r = pick_operand();
    case (fn)
      cia_pkg::FN_MUL: if ($urandom_range(0, 1)) begin
        l = longint'(int'($urandom)) >>> $urandom_range(0, 31);
        r = longint'(int'($urandom)) >>> $urandom_range(0, 31);
      end
      cia_pkg::FN_DIV: if ($urandom_range(0, 9) < 6) begin
        r = longint'($urandom_range(0, 2000)) - 1000;
        if (r == 0) r = -7;
        l = r * (longint'(int'($urandom)) >>> $urandom_range(0, 30));
      end
      cia_pkg::FN_POW: if ($urandom_range(0, 9) != 0) begin
        l = $urandom_range(0, 3) == 0 ? pick_operand() : longint'($urandom_range(0, 10)) - 5;
        r = $urandom_range(0, 70);
      end
      default: ;
    endcase
    send_beat(fn, l, r);
  endtask

  initial begin
    int burst;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(cia_pkg::FN_ADD, I64_MAX, 1);
    send_beat(cia_pkg::FN_ADD, I64_MIN, -1);
    send_beat(cia_pkg::FN_ADD, I64_MAX, I64_MIN);
    send_beat(cia_pkg::FN_SUB, I64_MIN, 1);
    send_beat(cia_pkg::FN_SUB, 0, I64_MIN);
    send_beat(cia_pkg::FN_SUB, -1, I64_MAX);
    send_beat(cia_pkg::FN_MUL, I64_MIN, -1);
    send_beat(cia_pkg::FN_MUL, I64_MIN, 1);
    send_beat(cia_pkg::FN_MUL, 64'sh1_0000_0000, 64'sh8000_0000);
    send_beat(cia_pkg::FN_MUL, -64'sh1_0000_0000, 64'sh8000_0000);
    send_beat(cia_pkg::FN_DIV, I64_MIN, -1);
    send_beat(cia_pkg::FN_DIV, 7, 0);
    send_beat(cia_pkg::FN_DIV, 7, 2);
    send_beat(cia_pkg::FN_DIV, I64_MIN, 2);
    send_beat(cia_pkg::FN_MOD, I64_MIN, -1);
    send_beat(cia_pkg::FN_MOD, -7, 3);
    send_beat(cia_pkg::FN_MOD, 5, 0);
    send_beat(cia_pkg::FN_POW, 0, 0);
    send_beat(cia_pkg::FN_POW, 2, 62);
    send_beat(cia_pkg::FN_POW, -2, 63);
    send_beat(cia_pkg::FN_POW, 2, 63);
    send_beat(cia_pkg::FN_POW, 3, -1);
    send_beat(cia_pkg::FN_POW, -1, I64_MAX);
    send_beat(FN_SPARE_LO, I64_MAX, I64_MIN);
    send_beat(FN_SPARE_HI, -1, -1);
    pause(3);

    for (int i = 0; i < N_RANDOM; ) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst && i < N_RANDOM; j++, i++) send_random();
      if (i >= N_RANDOM / 2 && i - burst < N_RANDOM / 2) begin
        start <= 1'b0;
        // wait on the clock so the last accepted beat is already noted
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
      end else if ($urandom_range(0, 3) != 0) begin
        pause($urandom_range(1, 8));
      end
    end
    start <= 1'b0;
    @(posedge clk);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[checked_int64_alu.f]
rtl/cia_pkg.sv
rtl/cia_mul.sv
rtl/cia_div.sv
rtl/checked_int64_alu.sv
rtl/cia_chk.sv
verif/checked_int64_alu_tb.sv
